// ===== design/integer_gcd_lcm_mod_unit_macros.svh =====
// Assertion macros shared by the checkers of the gcd / lcm / modulus unit.
// Depends on nothing; included by the checker file.
`ifndef INTEGER_GCD_LCM_MOD_UNIT_MACROS_SVH
`define INTEGER_GCD_LCM_MOD_UNIT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define IGL_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checks that a condition never holds outside reset.
`define IGL_ASSERT_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ===== design/igl_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants and types of the gcd / lcm / modulus unit.
// Depends on nothing; used by the unit, datapath, controller and checker files.
package igl_pkg;

  localparam int DATA_BITS_DEF = 31;

  localparam logic [1:0] OP_GCD = 2'd0;
  localparam logic [1:0] OP_LCM = 2'd1;
  localparam logic [1:0] OP_MOD = 2'd2;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_ERR = 2'd1;
  localparam logic [1:0] ST_SAT = 2'd2;

  typedef enum logic [1:0] {
    SEL_ERR = 2'd0,
    SEL_GCD = 2'd1,
    SEL_REM = 2'd2,
    SEL_LCM = 2'd3
  } sel_t;

  typedef struct packed {
    logic load;
    logic gcd_step;
    logic div_load;
    logic div_step;
    logic mul_load;
    logic mul_step;
    sel_t sel;
  } igl_ctrl_t;

  typedef struct packed {
    logic a_zero;
    logic b_zero;
    logic gcd_equal;
    logic count_last;
  } igl_stat_t;

endpackage

// ===== design/integer_gcd_lcm_mod_unit.sv =====
`timescale 1ns / 1ps
// An error goes straight to the output state, a modulus runs the divider and a
// gcd runs the binary gcd steps until both values are equal; an lcm runs the gcd,
// divides a by it and multiplies the quotient by b. The divider and the multiplier
// each retire one bit per cycle. One transaction at a time: busy stays high until the
// cycle of done, and the next start is taken the cycle after. Reset clears the
// controller to idle; the result strobe cannot be stalled by the receiver.
module integer_gcd_lcm_mod_unit #(
  parameter int DATA_BITS = igl_pkg::DATA_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [1:0]           cmd,
  input  logic [DATA_BITS-1:0] operand_a,
  input  logic [DATA_BITS-1:0] operand_b,
  output logic                 busy,
  output logic                 done,
  output logic [DATA_BITS-1:0] result_value,
  output logic [1:0]           status
);
  import igl_pkg::*;

  igl_ctrl_t ctrl;
  igl_stat_t stat;

  igl_controller u_controller (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .cmd   (cmd),
    .stat  (stat),
    .ctrl  (ctrl),
    .busy  (busy),
    .done  (done)
  );

  igl_datapath #(
    .DATA_BITS (DATA_BITS)
  ) u_datapath (
    .clk          (clk),
    .ctrl         (ctrl),
    .operand_a    (operand_a),
    .operand_b    (operand_b),
    .stat         (stat),
    .result_value (result_value),
    .status       (status)
  );

endmodule

// ===== design/igl_datapath.sv =====
`timescale 1ns / 1ps
// Datapath of the gcd / lcm / modulus unit: binary gcd, restoring divider and
// shift-add multiplier sharing one register set. Depends on igl_pkg.
module igl_datapath #(
  parameter int DATA_BITS = igl_pkg::DATA_BITS_DEF
) (
  input  logic                   clk,
  input  igl_pkg::igl_ctrl_t     ctrl,
  input  logic [DATA_BITS-1:0]   operand_a,
  input  logic [DATA_BITS-1:0]   operand_b,
  output igl_pkg::igl_stat_t     stat,
  output logic [DATA_BITS-1:0]   result_value,
  output logic [1:0]             status
);
  import igl_pkg::*;

  localparam int N  = DATA_BITS;
  localparam int KW = $clog2(DATA_BITS + 1);
  localparam int CW = $clog2(DATA_BITS);
  localparam logic [CW-1:0] COUNT_LAST = CW'(DATA_BITS - 1);
  localparam logic [N-1:0] VAL_MAX = '1;

  logic [N-1:0]  x;
  logic [N-1:0]  y;
  logic [N+1:0]  acc;
  logic [N-1:0]  a_reg;
  logic [N-1:0]  b_reg;
  logic [KW-1:0] shift_k;
  logic [CW-1:0] count;
  logic          sat;

  logic [N-1:0]  diff_xy;
  logic [N-1:0]  diff_yx;
  logic [N-1:0]  x_gcd;
  logic [N-1:0]  y_gcd;
  logic [KW-1:0] k_gcd;
  logic [N-1:0]  gcd_val;
  logic [N:0]    div_shift;
  logic [N:0]    div_diff;
  logic          div_ge;
  logic [N+1:0]  mul_sum;
  logic          mul_over;

  assign diff_xy = x - y;
  assign diff_yx = y - x;
  assign gcd_val = x << shift_k;

  always_comb begin
    x_gcd = x;
    y_gcd = y;
    k_gcd = shift_k;
    if (!x[0] && !y[0]) begin
      x_gcd = x >> 1;
      y_gcd = y >> 1;
      k_gcd = shift_k + KW'(1);
    end else if (!x[0]) begin
      x_gcd = x >> 1;
    end else if (!y[0]) begin
      y_gcd = y >> 1;
    end else if (x > y) begin
      x_gcd = diff_xy >> 1;
    end else begin
      y_gcd = diff_yx >> 1;
    end
  end

  assign div_shift = {acc[N-1:0], x[N-1]};
  assign div_ge    = div_shift >= {1'b0, y};
  assign div_diff  = div_shift - {1'b0, y};

  assign mul_sum  = {acc[N:0], 1'b0} + (x[N-1] ? {2'b00, b_reg} : {(N+2){1'b0}});
  assign mul_over = mul_sum > {2'b00, VAL_MAX};

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      a_reg   <= operand_a;
      b_reg   <= operand_b;
      x       <= operand_a;
      y       <= operand_b;
      acc     <= '0;
      shift_k <= '0;
      count   <= '0;
      sat     <= 1'b0;
    end
    if (ctrl.gcd_step) begin
      x       <= x_gcd;
      y       <= y_gcd;
      shift_k <= k_gcd;
    end
    if (ctrl.div_load) begin
      x     <= a_reg;
      y     <= gcd_val;
      acc   <= '0;
      count <= '0;
    end
    if (ctrl.div_step) begin
      x     <= {x[N-2:0], div_ge};
      acc   <= {1'b0, (div_ge ? div_diff : div_shift)};
      count <= (count == COUNT_LAST) ? '0 : count + CW'(1);
    end
    if (ctrl.mul_load) begin
      acc <= '0;
    end
    if (ctrl.mul_step) begin
      x     <= {x[N-2:0], 1'b0};
      acc   <= mul_sum;
      count <= (count == COUNT_LAST) ? '0 : count + CW'(1);
      if (mul_over) begin
        sat <= 1'b1;
      end
    end
  end

  assign stat.a_zero     = (operand_a == '0);
  assign stat.b_zero     = (operand_b == '0);
  assign stat.gcd_equal  = (x == y);
  assign stat.count_last = (count == COUNT_LAST);

  always_comb begin
    result_value = '0;
    status       = ST_ERR;
    unique case (ctrl.sel)
      SEL_ERR: begin
        result_value = '0;
        status       = ST_ERR;
      end
      SEL_GCD: begin
        result_value = gcd_val;
        status       = ST_OK;
      end
      SEL_REM: begin
        result_value = acc[N-1:0];
        status       = ST_OK;
      end
      SEL_LCM: begin
        result_value = sat ? VAL_MAX : acc[N-1:0];
        status       = sat ? ST_SAT : ST_OK;
      end
      default: begin
        result_value = '0;
        status       = ST_ERR;
      end
    endcase
  end

endmodule

// ===== design/igl_controller.sv =====
`timescale 1ns / 1ps
// Controller of the gcd / lcm / modulus unit: sequences the datapath through
// the gcd, divide and multiply phases. Depends on igl_pkg.
module igl_controller (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [1:0]         cmd,
  input  igl_pkg::igl_stat_t stat,
  output igl_pkg::igl_ctrl_t ctrl,
  output logic               busy,
  output logic               done
);
  import igl_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_GCD  = 5'b00010,
    S_DIV  = 5'b00100,
    S_MUL  = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t     state;
  state_t     state_next;
  sel_t       sel;
  sel_t       sel_next;
  logic [1:0] op;
  logic [1:0] op_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      sel   <= SEL_ERR;
      op    <= OP_GCD;
    end else begin
      state <= state_next;
      sel   <= sel_next;
      op    <= op_next;
    end
  end

  always_comb begin
    state_next = state;
    sel_next   = sel;
    op_next    = op;
    ctrl       = '0;
    ctrl.sel   = sel;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          ctrl.load = 1'b1;
          op_next   = cmd;
          case (cmd) inside
            OP_GCD, OP_LCM: begin
              if (stat.a_zero || stat.b_zero) begin
                sel_next   = SEL_ERR;
                state_next = S_OUT;
              end else begin
                state_next = S_GCD;
              end
            end
            OP_MOD: begin
              if (stat.b_zero) begin
                sel_next   = SEL_ERR;
                state_next = S_OUT;
              end else begin
                state_next = S_DIV;
              end
            end
            default: begin
              sel_next   = SEL_ERR;
              state_next = S_OUT;
            end
          endcase
        end
      end
      S_GCD: begin
        if (stat.gcd_equal) begin
          if (op == OP_GCD) begin
            sel_next   = SEL_GCD;
            state_next = S_OUT;
          end else begin
            ctrl.div_load = 1'b1;
            state_next    = S_DIV;
          end
        end else begin
          ctrl.gcd_step = 1'b1;
        end
      end
      S_DIV: begin
        ctrl.div_step = 1'b1;
        if (stat.count_last) begin
          if (op == OP_MOD) begin
            sel_next   = SEL_REM;
            state_next = S_OUT;
          end else begin
            ctrl.mul_load = 1'b1;
            state_next    = S_MUL;
          end
        end
      end
      S_MUL: begin
        ctrl.mul_step = 1'b1;
        if (stat.count_last) begin
          sel_next   = SEL_LCM;
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_OUT);

endmodule

// ===== design/igl_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker of the gcd / lcm / modulus unit and its bind statement.
// Depends on igl_pkg and integer_gcd_lcm_mod_unit_macros.svh.
`include "integer_gcd_lcm_mod_unit_macros.svh"

module igl_checker #(
  parameter int DATA_BITS = igl_pkg::DATA_BITS_DEF
) (
  input logic                 clk,
  input logic                 rst,
  input logic                 start,
  input logic                 busy,
  input logic                 done,
  input logic [DATA_BITS-1:0] result_value,
  input logic [1:0]           status
);
  import igl_pkg::*;

  // An accepted transaction always makes the unit busy in the next cycle.
  `IGL_ASSERT(a_start_busy, clk, rst, (start && !busy) |=> busy, "accepted start without busy")
  // The result strobe lasts exactly one cycle and the unit is idle afterwards.
  `IGL_ASSERT(a_done_pulse, clk, rst, done |=> (!done && !busy), "done held or unit stayed busy")
  `IGL_ASSERT(a_err_zero, clk, rst, (done && status == ST_ERR) |-> (result_value == '0), "error result not zero")
  `IGL_ASSERT(a_sat_max, clk, rst, (done && status == ST_SAT) |-> (result_value == '1), "saturated lcm not all ones")
  `IGL_ASSERT_NEVER(a_status_code, clk, rst, done && status != ST_OK && status != ST_ERR && status != ST_SAT, "undefined status code")

endmodule

bind integer_gcd_lcm_mod_unit igl_checker #(
  .DATA_BITS (DATA_BITS)
) u_igl_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .done         (done),
  .result_value (result_value),
  .status       (status)
);
